// ----- hdl/assert_macros.svh -----
// Assertion macros for the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising edge, quiet while reset is asserted.
`define ASSERT_CHK(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
		else $error("port check failed");

// Check that a condition never holds at a rising edge.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
	`ASSERT_CHK(lbl, clk, rstn, !(expr))

`endif

// ----- hdl/mpvs_pkg.sv -----
package mpvs_pkg;

	localparam int SLOTS      = 16;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int IN_SLOT_W  = 4;
	localparam int HEAP_W     = 48;
	localparam int AGE_W      = 32;
	localparam int PRIO_W     = 8;
	localparam int PCT_W      = 7;
	localparam int BUDGET_W   = 48;
	localparam int USED_W     = HEAP_W + SLOT_W;
	localparam int PROD_W     = USED_W + PCT_W;
	localparam int THR_W      = BUDGET_W + PCT_W;
	localparam int AGE1_W     = AGE_W + 1;
	localparam int PRIO1_W    = PRIO_W + 1;
	localparam int SCORE_W    = HEAP_W + AGE1_W;
	localparam int MUL_STEPS  = AGE1_W;
	localparam int DIV_STEPS  = SCORE_W;
	localparam int STEP_W     = $clog2(SCORE_W);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = BUDGET_W;
	localparam int TICK_W     = 64;
	localparam int EVCNT_W    = 32;
	localparam int LOW_W      = 32;

	localparam logic [CFG_IDX_W-1:0] REG_SOFT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HARD   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BUDGET = 2'd2;

	localparam logic KIND_SNAP = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [1:0] LVL_NONE = 2'd0;
	localparam logic [1:0] LVL_SOFT = 2'd1;
	localparam logic [1:0] LVL_HARD = 2'd2;

	localparam logic [PCT_W-1:0]    SOFT_RESET     = 7'd80;
	localparam logic [PCT_W-1:0]    HARD_RESET     = 7'd95;
	localparam logic [PCT_W-1:0]    SOFT_MAX       = 7'd99;
	localparam logic [PCT_W-1:0]    PCT_SCALE      = 7'd100;
	localparam logic [BUDGET_W-1:0] DEFAULT_BUDGET = 48'd206158430208;
	localparam logic [TICK_W-1:0]   COOLDOWN       = 64'd100;

	typedef struct packed {
		logic [HEAP_W-1:0] heap;
		logic [AGE_W-1:0]  age;
		logic [PRIO_W-1:0] prio;
		logic              pinned;
	} slot_entry_t;

	typedef struct packed {
		logic              start;
		logic [HEAP_W-1:0] heap;
		logic [AGE_W-1:0]  age;
		logic [PRIO_W-1:0] prio;
	} unit_req_t;

	typedef struct packed {
		logic               done;
		logic [SCORE_W-1:0] score;
	} unit_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SNAP_RD,
		S_SNAP_WR,
		S_TICK_MUL,
		S_TICK_LVL,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_SCAN_CALC,
		S_DONE
	} seq_state_t;

	typedef enum logic [1:0] {
		U_IDLE,
		U_MUL,
		U_DIV
	} unit_state_t;

	function automatic logic [SLOT_W-1:0] to_slot(input logic [IN_SLOT_W-1:0] s);
		return SLOT_W'(s);
	endfunction

	function automatic logic slot_in_range(input logic [IN_SLOT_W-1:0] s);
		return 32'(s) < SLOTS;
	endfunction

endpackage

// ----- hdl/mpvs_slot_mem.sv -----
module mpvs_slot_mem import mpvs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [SLOT_W-1:0] wr_addr,
	input  slot_entry_t       wr_data,
	input  logic [SLOT_W-1:0] rd_addr,
	output slot_entry_t       rd_data
);

	slot_entry_t mem_q [SLOTS];
	logic [SLOTS-1:0] valid_q;
	slot_entry_t rd_data_q;
	logic rd_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (we) valid_q[wr_addr] <= 1'b1;
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem_q[wr_addr] <= wr_data;
		rd_data_q <= mem_q[rd_addr];
	end

	// never-written entries read as zero
	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

// ----- hdl/mpvs_score_unit.sv -----
module mpvs_score_unit import mpvs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  unit_req_t req,
	output unit_rsp_t rsp
);

	unit_state_t state_q, state_d;
	logic [SCORE_W-1:0] acc_q;
	logic [SCORE_W-1:0] mcand_q;
	logic [AGE1_W-1:0]  mplr_q;
	logic [PRIO1_W-1:0] div_q;
	logic [PRIO_W-1:0]  rem_q;
	logic [STEP_W-1:0]  cnt_q;
	logic               done_q;
	logic mul_en, div_en, mul_last, div_last;
	logic [PRIO1_W-1:0] trial;
	logic               ge;

	assign mul_last = cnt_q == STEP_W'(MUL_STEPS - 1);
	assign div_last = cnt_q == STEP_W'(DIV_STEPS - 1);
	assign trial    = {rem_q, acc_q[SCORE_W-1]};
	assign ge       = trial >= div_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			U_IDLE: if (req.start) state_d = U_MUL;
			U_MUL:  if (mul_last) state_d = U_DIV;
			U_DIV:  if (div_last) state_d = U_IDLE;
			default: state_d = U_IDLE;
		endcase
	end

	always_comb begin
		mul_en = 1'b0;
		div_en = 1'b0;
		unique case (state_q)
			U_IDLE: ;
			U_MUL:  mul_en = 1'b1;
			U_DIV:  div_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= div_en && div_last;
		end
	end

	// shift-add multiply one multiplier bit a cycle, then restoring divide
	// one quotient bit a cycle; the quotient shifts into acc from the bottom
	always_ff @(posedge clk) begin
		if (req.start && state_q == U_IDLE) begin
			acc_q   <= '0;
			mcand_q <= SCORE_W'(req.heap);
			mplr_q  <= AGE1_W'(req.age) + AGE1_W'(1);
			div_q   <= PRIO1_W'(req.prio) + PRIO1_W'(1);
			rem_q   <= '0;
			cnt_q   <= '0;
		end else if (mul_en) begin
			if (mplr_q[0]) acc_q <= acc_q + mcand_q;
			mcand_q <= mcand_q << 1;
			mplr_q  <= mplr_q >> 1;
			cnt_q   <= mul_last ? '0 : cnt_q + STEP_W'(1);
		end else if (div_en) begin
			rem_q <= ge ? PRIO_W'(trial - div_q) : trial[PRIO_W-1:0];
			acc_q <= {acc_q[SCORE_W-2:0], ge};
			cnt_q <= cnt_q + STEP_W'(1);
		end
	end

	assign rsp.done  = done_q;
	assign rsp.score = acc_q;

endmodule

// ----- hdl/memory_pressure_victim_selector.sv -----
// Snapshot: busy through the read and write states after the accepting edge; a new
// beat is taken only back in idle. Tick: multiply, level, then a scan of the slots,
// ending at once when no eviction is tried, else each active unpinned slot is scored
// by the serial multiply/divide unit. Busy drops in the cycle after done.
// One item at a time; done pulses one cycle per tick and cannot be stalled.
// Async reset (arst_n low) clears tables, counters and state; config regs to defaults.
module memory_pressure_victim_selector import mpvs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  kind,
	input  logic [IN_SLOT_W-1:0]  slot_number,
	input  logic [HEAP_W-1:0]     heap_bytes,
	input  logic [AGE_W-1:0]      slot_age,
	input  logic [PRIO_W-1:0]     slot_priority,
	input  logic                  slot_pinned,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output logic [1:0]            pressure_level,
	output logic                  evicted,
	output logic [IN_SLOT_W-1:0]  evict_slot,
	output logic                  snapshot_first,
	output logic [EVCNT_W-1:0]    eviction_total,
	output logic [IN_SLOT_W-1:0]  last_victim,
	output logic [LOW_W-1:0]      used_total_low
);

	seq_state_t state_q, state_d;

	// configuration registers
	logic [PCT_W-1:0]    soft_q, hard_q;
	logic [BUDGET_W-1:0] budget_q;
	logic [BUDGET_W-1:0] budget_eff;

	// persistent state
	logic [USED_W-1:0]  used_q;
	logic [TICK_W-1:0]  tick_q;
	logic [TICK_W-1:0]  last_evict_q;
	logic [EVCNT_W-1:0] evcnt_q;
	logic [SLOT_W-1:0]  last_victim_q;

	// captured beat
	logic [SLOT_W-1:0] snap_slot_q;
	logic              snap_ok_q;
	slot_entry_t       snap_q;

	// tick work
	logic [PROD_W-1:0] used100_q;
	logic [THR_W-1:0]  hard_thr_q, soft_thr_q;
	logic [1:0]        level_q;
	logic              hard_hit_q, try_q;
	logic [SLOT_W-1:0] idx_q;
	logic              found_q;
	logic [SLOT_W-1:0] victim_q;
	logic [SCORE_W-1:0] best_q;

	// result registers
	logic [1:0]           lvl_out_q;
	logic                 ev_out_q, snap_out_q;
	logic [IN_SLOT_W-1:0] victim_out_q, last_out_q;
	logic [EVCNT_W-1:0]   evcnt_out_q;
	logic [LOW_W-1:0]     used_out_q;

	// memory and unit hookup
	logic              mem_we, rd_snap, unit_start;
	logic [SLOT_W-1:0] rd_addr;
	slot_entry_t       rd_data;
	unit_req_t         ureq;
	unit_rsp_t         ursp;

	logic accept, last_idx, candidate, finish, ev_now, cool_ok, better;
	logic take, found_now;
	logic [SLOT_W-1:0] victim_now;

	assign accept    = start && !busy;
	assign last_idx  = idx_q == SLOT_W'(SLOTS - 1);
	assign candidate = (rd_data.heap != '0) && !rd_data.pinned;
	assign finish    = (state_q != S_DONE) && (state_d == S_DONE);
	// the last slot's score lands on the same edge as finish; fold it in here
	assign take       = (state_q == S_SCAN_CALC) && ursp.done && better;
	assign found_now  = found_q || take;
	assign victim_now = take ? idx_q : victim_q;
	assign ev_now    = try_q && found_now;
	assign cool_ok   = (tick_q - last_evict_q) >= COOLDOWN;
	assign better    = !found_q || (ursp.score < best_q);
	assign budget_eff = (budget_q == '0) ? DEFAULT_BUDGET : budget_q;

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = (kind == KIND_TICK) ? S_TICK_MUL : S_SNAP_RD;
			end
			S_SNAP_RD:  state_d = S_SNAP_WR;
			S_SNAP_WR:  state_d = S_IDLE;
			S_TICK_MUL: state_d = S_TICK_LVL;
			S_TICK_LVL: state_d = S_SCAN_RD;
			S_SCAN_RD:  state_d = S_SCAN_CHK;
			S_SCAN_CHK: begin
				// skip empty or pinned slots without touching the unit
				if (!try_q) state_d = S_DONE;
				else if (candidate) state_d = S_SCAN_CALC;
				else if (last_idx) state_d = S_DONE;
				else state_d = S_SCAN_RD;
			end
			S_SCAN_CALC: begin
				if (ursp.done) state_d = last_idx ? S_DONE : S_SCAN_RD;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		busy       = 1'b1;
		mem_we     = 1'b0;
		rd_snap    = 1'b0;
		unit_start = 1'b0;
		done       = 1'b0;
		unique case (state_q)
			S_IDLE:      busy = 1'b0;
			S_SNAP_RD:   rd_snap = 1'b1;
			S_SNAP_WR: begin
				rd_snap = 1'b1;
				mem_we  = snap_ok_q;
			end
			S_TICK_MUL:  ;
			S_TICK_LVL:  ;
			S_SCAN_RD:   ;
			S_SCAN_CHK:  unit_start = try_q && candidate;
			S_SCAN_CALC: ;
			S_DONE:      done = 1'b1;
			default:     ;
		endcase
	end

	assign rd_addr = rd_snap ? snap_slot_q : idx_q;

	assign ureq.start = unit_start;
	assign ureq.heap  = rd_data.heap;
	assign ureq.age   = rd_data.age;
	assign ureq.prio  = rd_data.prio;

	mpvs_slot_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (mem_we),
		.wr_addr (snap_slot_q),
		.wr_data (snap_q),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	mpvs_score_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ureq),
		.rsp    (ursp)
	);

	// configuration; an out-of-range soft level is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			soft_q   <= SOFT_RESET;
			hard_q   <= HARD_RESET;
			budget_q <= DEFAULT_BUDGET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SOFT: begin
					if (cfg_data[PCT_W-1:0] != '0 && cfg_data[PCT_W-1:0] <= SOFT_MAX)
						soft_q <= cfg_data[PCT_W-1:0];
				end
				REG_HARD:   hard_q   <= cfg_data[PCT_W-1:0];
				REG_BUDGET: budget_q <= cfg_data[BUDGET_W-1:0];
				default:    ;
			endcase
		end
	end

	// control and persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			used_q        <= '0;
			tick_q        <= '0;
			last_evict_q  <= '0;
			evcnt_q       <= '0;
			last_victim_q <= '0;
			snap_ok_q     <= 1'b0;
			try_q         <= 1'b0;
			found_q       <= 1'b0;
			idx_q         <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				snap_ok_q <= (kind == KIND_SNAP) && slot_in_range(slot_number);
				// advance time before the levels are checked
				if (kind == KIND_TICK) tick_q <= tick_q + TICK_W'(1);
			end
			if (state_q == S_SNAP_WR && snap_ok_q)
				used_q <= used_q - USED_W'(rd_data.heap) + USED_W'(snap_q.heap);
			if (state_q == S_TICK_LVL) begin
				// hard level wins over soft
				if (PROD_W'(used100_q) >= PROD_W'(hard_thr_q)) try_q <= 1'b1;
				else if (PROD_W'(used100_q) >= PROD_W'(soft_thr_q)) try_q <= cool_ok;
				else try_q <= 1'b0;
				found_q <= 1'b0;
				idx_q   <= '0;
			end
			if (state_q == S_SCAN_CHK && try_q && !candidate && !last_idx)
				idx_q <= idx_q + SLOT_W'(1);
			if (state_q == S_SCAN_CALC && ursp.done) begin
				if (better) found_q <= 1'b1;
				if (!last_idx) idx_q <= idx_q + SLOT_W'(1);
			end
			if (finish && ev_now) begin
				evcnt_q       <= evcnt_q + EVCNT_W'(1);
				last_victim_q <= victim_now;
				last_evict_q  <= tick_q;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			snap_slot_q   <= to_slot(slot_number);
			snap_q.heap   <= heap_bytes;
			snap_q.age    <= slot_age;
			snap_q.prio   <= slot_priority;
			snap_q.pinned <= slot_pinned;
		end
		// pct >= level  <=>  used*100 >= level*budget
		if (state_q == S_TICK_MUL) begin
			used100_q  <= PROD_W'(used_q) * PROD_W'(PCT_SCALE);
			hard_thr_q <= THR_W'(hard_q) * THR_W'(budget_eff);
			soft_thr_q <= THR_W'(soft_q) * THR_W'(budget_eff);
		end
		if (state_q == S_TICK_LVL) begin
			if (PROD_W'(used100_q) >= PROD_W'(hard_thr_q)) begin
				level_q    <= LVL_HARD;
				hard_hit_q <= 1'b1;
			end else if (PROD_W'(used100_q) >= PROD_W'(soft_thr_q)) begin
				level_q    <= LVL_SOFT;
				hard_hit_q <= 1'b0;
			end else begin
				level_q    <= LVL_NONE;
				hard_hit_q <= 1'b0;
			end
		end
		// strict compare keeps the lowest slot id on ties
		if (state_q == S_SCAN_CALC && ursp.done && better) begin
			best_q   <= ursp.score;
			victim_q <= idx_q;
		end
		if (finish) begin
			lvl_out_q    <= level_q;
			ev_out_q     <= ev_now;
			snap_out_q   <= ev_now && !hard_hit_q;
			victim_out_q <= ev_now ? IN_SLOT_W'(victim_now) : '0;
			evcnt_out_q  <= ev_now ? evcnt_q + EVCNT_W'(1) : evcnt_q;
			last_out_q   <= ev_now ? IN_SLOT_W'(victim_now) : IN_SLOT_W'(last_victim_q);
			used_out_q   <= used_q[LOW_W-1:0];
		end
	end

	assign pressure_level = lvl_out_q;
	assign evicted        = ev_out_q;
	assign evict_slot     = victim_out_q;
	assign snapshot_first = snap_out_q;
	assign eviction_total = evcnt_out_q;
	assign last_victim    = last_out_q;
	assign used_total_low = used_out_q;

endmodule

// ----- hdl/mpvs_checker.sv -----
`include "assert_macros.svh"

module mpvs_checker import mpvs_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 done,
	input logic [1:0]           pressure_level,
	input logic                 evicted,
	input logic [IN_SLOT_W-1:0] evict_slot,
	input logic                 snapshot_first
);

	// an accepted beat holds the block busy
	`ASSERT_CHK(a_accept_busy, clk, arst_n, start && !busy |=> busy)
	// a result shows while busy, and the block frees up right after it
	`ASSERT_CHK(a_done_busy, clk, arst_n, done |-> busy)
	`ASSERT_CHK(a_done_single, clk, arst_n, done |=> !done && !busy)
	// no victim fields without an eviction
	`ASSERT_NEVER(a_idle_victim, clk, arst_n,
		done && !evicted && (evict_slot != '0 || snapshot_first))
	// snapshot request only on a soft eviction
	`ASSERT_NEVER(a_snap_soft, clk, arst_n,
		done && snapshot_first && (!evicted || pressure_level != LVL_SOFT))

endmodule

bind memory_pressure_victim_selector mpvs_checker u_mpvs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.pressure_level (pressure_level),
	.evicted        (evicted),
	.evict_slot     (evict_slot),
	.snapshot_first (snapshot_first)
);
